@@ src/msp_pkg.sv @@
// Shared constants, types and the search select struct for the saddle-point finder.
// No dependencies.
`timescale 1ns / 1ps

package msp_pkg;

  localparam int MAX_SIZE    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(MAX_SIZE);
  localparam int SIZE_W      = 5;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [SIZE_W-1:0]             size_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
    logic pass;
  } sel_t;

endpackage

@@ src/msp_if.sv @@
// Valid/ready channel interfaces for element items and result items.
// Depends on msp_pkg.
`timescale 1ns / 1ps

interface msp_in_if import msp_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface msp_out_if import msp_pkg::*; ();
  logic valid;
  logic ready;
  logic found;
  idx_t row_index;
  idx_t column_index;

  modport source (output valid, output found, output row_index, output column_index,
                  input ready);
  modport sink (input valid, input found, input row_index, input column_index,
                output ready);
endinterface

@@ src/msp_tracker.sv @@
// Row and column extreme trackers with the row/column counters of the load phase.
// Depends on msp_pkg.
`timescale 1ns / 1ps

module msp_tracker import msp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   clear,
  input  logic   load_en,
  input  value_t value,
  input  idx_t   last_idx,
  input  sel_t   sel,
  output logic   done,
  output value_t a_val,
  output value_t b_val
);

  idx_t   row_r, row_nxt;
  idx_t   col_r, col_nxt;
  value_t run_max_r, run_min_r;
  value_t row_max_r [MAX_SIZE];
  value_t row_min_r [MAX_SIZE];
  value_t col_min_r [MAX_SIZE];
  value_t col_max_r [MAX_SIZE];

  value_t rmax, rmin, cmin, cmax, cmin_old, cmax_old;
  logic   row_end;

  assign row_end  = (col_r == last_idx);
  assign done     = load_en && row_end && (row_r == last_idx);
  assign cmin_old = col_min_r[col_r];
  assign cmax_old = col_max_r[col_r];

  always_comb begin
    rmax = run_max_r;
    rmin = run_min_r;
    cmin = cmin_old;
    cmax = cmax_old;
    if (col_r == '0 || value > run_max_r) rmax = value;
    if (col_r == '0 || value < run_min_r) rmin = value;
    if (row_r == '0 || value < cmin_old) cmin = value;
    if (row_r == '0 || value > cmax_old) cmax = value;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (clear) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (load_en) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_r == last_idx) ? '0 : row_r + idx_t'(1);
      end else begin
        col_nxt = col_r + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      run_max_r        <= rmax;
      run_min_r        <= rmin;
      col_min_r[col_r] <= cmin;
      col_max_r[col_r] <= cmax;
      if (row_end) begin
        row_max_r[row_r] <= rmax;
        row_min_r[row_r] <= rmin;
      end
    end
  end

  assign a_val = sel.pass ? row_min_r[sel.row] : row_max_r[sel.row];
  assign b_val = sel.pass ? col_max_r[sel.col] : col_min_r[sel.col];

endmodule

@@ src/msp_search.sv @@
// Pair search sequencer around one shared equality compare, with the result register.
// Depends on msp_pkg.
`timescale 1ns / 1ps

module msp_search import msp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  idx_t   last_idx,
  input  value_t a_val,
  input  value_t b_val,
  input  logic   out_ready,
  output logic   loading,
  output sel_t   sel,
  output logic   out_valid,
  output logic   out_found,
  output idx_t   out_row,
  output idx_t   out_col
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  idx_t       sr_r, sr_nxt;
  idx_t       sc_r, sc_nxt;
  logic       pass_r, pass_nxt;
  logic       found_r, found_nxt;
  idx_t       ri_r, ri_nxt;
  idx_t       ci_r, ci_nxt;
  logic       hit;

  assign hit = (a_val == b_val);

  always_comb begin
    state_nxt = state_r;
    sr_nxt    = sr_r;
    sc_nxt    = sc_r;
    pass_nxt  = pass_r;
    found_nxt = found_r;
    ri_nxt    = ri_r;
    ci_nxt    = ci_r;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          state_nxt = ST_SRCH;
          sr_nxt    = '0;
          sc_nxt    = '0;
          pass_nxt  = 1'b0;
        end
      end
      ST_SRCH: begin
        if (hit) begin
          state_nxt = ST_OUT;
          found_nxt = 1'b1;
          ri_nxt    = sr_r;
          ci_nxt    = sc_r;
        end else if (sc_r != last_idx) begin
          sc_nxt = sc_r + idx_t'(1);
        end else if (sr_r != last_idx) begin
          sc_nxt = '0;
          sr_nxt = sr_r + idx_t'(1);
        end else if (!pass_r) begin
          sc_nxt   = '0;
          sr_nxt   = '0;
          pass_nxt = 1'b1;
        end else begin
          state_nxt = ST_OUT;
          found_nxt = 1'b0;
          ri_nxt    = '0;
          ci_nxt    = '0;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r    <= sr_nxt;
    sc_r    <= sc_nxt;
    pass_r  <= pass_nxt;
    found_r <= found_nxt;
    ri_r    <= ri_nxt;
    ci_r    <= ci_nxt;
  end

  assign loading   = (state_r == ST_LOAD);
  assign sel       = '{row: sr_r, col: sc_r, pass: pass_r};
  assign out_valid = (state_r == ST_OUT);
  assign out_found = found_r;
  assign out_row   = ri_r;
  assign out_col   = ci_r;

endmodule

@@ src/matrix_saddle_point_finder.sv @@
// Top level of the saddle-point finder: size register, trackers and pair search.
// Depends on msp_pkg, msp_if, msp_tracker and msp_search.
//
//   channel  dir  payload                               handshake
//   in_ch    in   element_value                         valid/ready
//   out_ch   out  found, row_index, column_index        valid/ready
//   cfg      in   cfg_data (matrix_size)                cfg_we, no wait
//
// Loading takes one element item per cycle while valid is high; ready stays high while loading.
// After the last element the shared compare walks up to 2*n*n pairs, one per cycle.
// The result is held in the output register until taken; no item is taken meanwhile.
// Reset (synchronous) returns size to 1 and the counters to the matrix origin.
`timescale 1ns / 1ps

module matrix_saddle_point_finder import msp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  size_t     cfg_data,
  msp_in_if.sink    in_ch,
  msp_out_if.source out_ch
);

  size_t  size_r;
  idx_t   last_idx;
  logic   load_en;
  logic   done;
  logic   loading;
  sel_t   sel;
  value_t a_val, b_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= size_t'(1);
    end else if (cfg_we) begin
      size_r <= cfg_data;
    end
  end

  always_comb begin
    priority if (size_r == '0) begin
      last_idx = '0;
    end else if (size_r > size_t'(MAX_SIZE)) begin
      last_idx = idx_t'(MAX_SIZE - 1);
    end else begin
      last_idx = size_r[IDX_W-1:0] - idx_t'(1);
    end
  end

  assign in_ch.ready = loading;
  assign load_en     = in_ch.valid && loading;

  msp_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_we),
    .load_en  (load_en),
    .value    (in_ch.element_value),
    .last_idx (last_idx),
    .sel      (sel),
    .done     (done),
    .a_val    (a_val),
    .b_val    (b_val)
  );

  msp_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (done),
    .last_idx  (last_idx),
    .a_val     (a_val),
    .b_val     (b_val),
    .out_ready (out_ch.ready),
    .loading   (loading),
    .sel       (sel),
    .out_valid (out_ch.valid),
    .out_found (out_ch.found),
    .out_row   (out_ch.row_index),
    .out_col   (out_ch.column_index)
  );

endmodule

@@ tb/sv/matrix_saddle_point_finder_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for matrix_saddle_point_finder: streams matrices of many sizes and
// fills, predicts each saddle search result and checks it field by field.
// Depends on msp_pkg, msp_if and the matrix_saddle_point_finder RTL.

module matrix_saddle_point_finder_test;
  import msp_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int DRAIN_CYCLES  = 16;
  localparam int SEARCH_CYCLES = 2 * MAX_SIZE * MAX_SIZE + 16;
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam int unsigned SIZE_FIELD_MAX = (1 << SIZE_W) - 1;

  typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_MAX_MIN, FILL_MIN_MAX, FILL_CONSTANT} fill_t;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } saddle_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we;
  size_t cfg_data;

  msp_in_if  in_ch();
  msp_out_if out_ch();

  matrix_saddle_point_finder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #5 clk = ~clk;

  value_t      row_hi [MAX_SIZE];
  value_t      row_lo [MAX_SIZE];
  value_t      col_lo [MAX_SIZE];
  value_t      col_hi [MAX_SIZE];
  int unsigned load_row;
  int unsigned load_col;
  int unsigned matrix_n;
  saddle_t     pending_saddles[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned stall_request = 0;
  int unsigned elements_sent = 0;
  int unsigned saddles_checked = 0;
  int unsigned saddles_found = 0;
  int unsigned error_count = 0;

  function automatic void clear_trackers();
    for (int i = 0; i < MAX_SIZE; i++) begin
      row_hi[i] = VALUE_MIN;
      row_lo[i] = VALUE_MAX;
      col_lo[i] = VALUE_MAX;
      col_hi[i] = VALUE_MIN;
    end
    load_row = 0;
    load_col = 0;
  endfunction

  function automatic void apply_size(input int unsigned n);
    if (n == 0) matrix_n = 1;
    else if (n > MAX_SIZE) matrix_n = MAX_SIZE;
    else matrix_n = n;
    clear_trackers();
  endfunction

  function automatic saddle_t search_saddle(input bit min_max);
    saddle_t s;
    s = '0;
    for (int r = 0; r < matrix_n; r++) begin
      for (int c = 0; c < matrix_n; c++) begin
        if (!s.found && (min_max ? row_lo[r] == col_hi[c] : row_hi[r] == col_lo[c])) begin
          s.found = 1'b1;
          s.row = idx_t'(r);
          s.col = idx_t'(c);
        end
      end
    end
    return s;
  endfunction

  function automatic void track_element(input value_t v);
    saddle_t s;
    if (v > row_hi[load_row]) row_hi[load_row] = v;
    if (v < row_lo[load_row]) row_lo[load_row] = v;
    if (v < col_lo[load_col]) col_lo[load_col] = v;
    if (v > col_hi[load_col]) col_hi[load_col] = v;
    if (load_col + 1 < matrix_n) begin
      load_col++;
    end else if (load_row + 1 < matrix_n) begin
      load_col = 0;
      load_row++;
    end else begin
      s = search_saddle(1'b0);
      if (!s.found) s = search_saddle(1'b1);
      pending_saddles.push_back(s);
      clear_trackers();
    end
  endfunction

  // Call at a falling edge; returns at a falling edge with cfg_we low again.
  task automatic write_size(input int unsigned n);
    cfg_we <= 1'b1;
    cfg_data <= size_t'(n);
    @(posedge clk);
    apply_size(n);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Call at a falling edge; valid stays high on return so back-to-back items flow.
  task automatic send_element(input value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_element(v);
    elements_sent++;
    @(negedge clk);
  endtask

  task automatic drain(input int unsigned extra);
    in_ch.valid <= 1'b0;
    while (pending_saddles.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic send_matrix(input fill_t fill);
    int unsigned n;
    int unsigned pr;
    int unsigned pc;
    value_t      pivot;
    value_t      x;
    n = matrix_n;
    pr = $urandom_range(n - 1);
    pc = $urandom_range(n - 1);
    case ($urandom_range(7))
      0: pivot = VALUE_MIN;
      1: pivot = VALUE_MAX;
      2: pivot = value_t'(int'($urandom_range(4)) - 2);
      default: pivot = value_t'($urandom);
    endcase
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        x = value_t'($urandom);
        case (fill)
          FILL_NARROW: x = value_t'(int'($urandom_range(4)) - 2);
          FILL_CONSTANT: x = pivot;
          FILL_MAX_MIN: begin
            if (r == pr && x > pivot) x = pivot;
            if (c == pc && x < pivot) x = pivot;
          end
          FILL_MIN_MAX: begin
            if (r == pr && x < pivot) x = pivot;
            if (c == pc && x > pivot) x = pivot;
          end
          default: ;
        endcase
        send_element(x);
      end
    end
  endtask

  task automatic test_single_elements();
    send_element(VALUE_MIN);
    send_element(VALUE_MAX);
    send_element('0);
    send_element(-1);
    drain(DRAIN_CYCLES);
    write_size(0);
    send_element(32'sh5555_5555);
    drain(DRAIN_CYCLES);
  endtask

  task automatic test_small_matrices();
    value_t corners[4]   = '{VALUE_MIN, VALUE_MAX, -1, 0};
    value_t diagonal[4]  = '{1, 0, 0, 1};
    value_t partial[4]   = '{VALUE_MAX, VALUE_MIN, 3, -3};
    value_t flat[4]      = '{7, 7, 7, 7};
    write_size(2);
    foreach (corners[i]) send_element(corners[i]);
    foreach (diagonal[i]) send_element(diagonal[i]);
    drain(DRAIN_CYCLES);
    write_size(3);
    foreach (partial[i]) send_element(partial[i]);
    drain(DRAIN_CYCLES);
    write_size(2);
    foreach (flat[i]) send_element(flat[i]);
    drain(DRAIN_CYCLES);
  endtask

  task automatic test_full_size();
    write_size(MAX_SIZE);
    repeat (20) send_element(value_t'($urandom));
    drain(DRAIN_CYCLES);
    write_size(SIZE_FIELD_MAX);
    send_matrix(FILL_MAX_MIN);
    drain(DRAIN_CYCLES);
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(1);
    stall_request = 200;
    repeat (24) send_element(value_t'($urandom));
    drain(DRAIN_CYCLES);
  endtask

  task automatic test_random_matrices(input int send_pct, input int recv_pct,
                                      input int unsigned item_target);
    int unsigned stop_at;
    fill_t       fill;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = elements_sent + item_target;
    while (elements_sent < stop_at) begin
      write_size($urandom_range(7));
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(9))
          0, 1:    fill = FILL_RANDOM;
          2, 3:    fill = FILL_NARROW;
          4, 5, 6: fill = FILL_MAX_MIN;
          7, 8:    fill = FILL_MIN_MAX;
          default: fill = FILL_CONSTANT;
        endcase
        send_matrix(fill);
      end
      drain(DRAIN_CYCLES);
    end
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    saddle_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_saddles.size() == 0) begin
        $display("%0t: unexpected result found=%0b row=%0d col=%0d", $time,
                 out_ch.found, out_ch.row_index, out_ch.column_index);
        error_count++;
      end else begin
        want = pending_saddles.pop_front();
        saddles_checked++;
        if (want.found) saddles_found++;
        if (out_ch.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_ch.found);
          error_count++;
        end
        if (out_ch.row_index !== want.row) begin
          $display("%0t: row_index expected %0d actual %0d", $time, want.row,
                   out_ch.row_index);
          error_count++;
        end
        if (out_ch.column_index !== want.col) begin
          $display("%0t: column_index expected %0d actual %0d", $time, want.col,
                   out_ch.column_index);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("matrix_saddle_point_finder_test: errors");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.element_value = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    matrix_n = 1;
    clear_trackers();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_single_elements();
    test_small_matrices();
    test_full_size();
    test_back_pressure();
    test_random_matrices(20, 56, 35);
    test_random_matrices(56, 20, 35);
    test_random_matrices(0, 0, 35);
    drain(SEARCH_CYCLES);

    $display("covered %0d elements and %0d matrices of size 1 to %0d, size writes mid-matrix,",
             elements_sent, saddles_checked, MAX_SIZE);
    $display("out-of-range sizes and output stalls; %0d matrices held a saddle pair",
             saddles_found);
    if (error_count == 0) begin
      $display("matrix_saddle_point_finder_test: clean");
    end else begin
      $display("matrix_saddle_point_finder_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/msp_pkg.sv
src/msp_if.sv
src/msp_tracker.sv
src/msp_search.sv
src/matrix_saddle_point_finder.sv
tb/sv/matrix_saddle_point_finder_test.sv
